[design/swm_pkg.sv]
// Package with shared constants and types of the sliding window median filter.
`default_nettype none
package swm_pkg;

    localparam int SAMPLE_W        = 30;
    localparam int WS_W            = 7;
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int GROUP_SIZE      = 8;
    localparam logic [WS_W-1:0] WS_RESET = 7'd3;

    typedef struct packed {
        logic insert;
        logic remove;
        logic clear;
    } swm_ctrl_t;

endpackage
`default_nettype wire

[design/swm_cell.sv]
// One cell of the sorted chain: holds one window entry and shifts with its neighbors.
`default_nettype none
module swm_cell #(
    parameter int AW    = 6,
    parameter int CW    = 7,
    parameter int INDEX = 0
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  swm_pkg::swm_ctrl_t                 ctrl,
    input  wire  [swm_pkg::SAMPLE_W-1:0]       sample,
    input  wire  [AW-1:0]                      oldest,
    input  wire  [CW-1:0]                      rank,
    input  wire                                left_valid,
    input  wire                                left_gt,
    input  wire  [swm_pkg::SAMPLE_W-1:0]       left_val,
    input  wire  [AW-1:0]                      left_age,
    input  wire                                right_valid,
    input  wire  [swm_pkg::SAMPLE_W-1:0]       right_val,
    input  wire  [AW-1:0]                      right_age,
    input  wire                                prefix_in,
    output logic                               self_valid,
    output logic                               self_gt,
    output logic [swm_pkg::SAMPLE_W-1:0]       self_val,
    output logic [AW-1:0]                      self_age,
    output logic                               prefix_out,
    output logic [swm_pkg::SAMPLE_W-1:0]       masked_val
);
    import swm_pkg::*;

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic                valid_reg;
    logic                valid_next;
    logic [SAMPLE_W-1:0] val_reg;
    logic [SAMPLE_W-1:0] val_next;
    logic [AW-1:0]       age_reg;
    logic [AW-1:0]       age_next;

    assign self_valid = valid_reg;
    assign self_val   = val_reg;
    assign self_age   = age_reg;
    assign self_gt    = valid_reg && (val_reg > sample);
    assign prefix_out = prefix_in || (valid_reg && (age_reg == oldest));
    assign masked_val = (valid_reg && (rank == MY_INDEX)) ? val_reg : '0;

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        age_next   = age_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (left_gt)
            begin
                valid_next = 1'b1;
                val_next   = left_val;
                age_next   = left_age + 1'b1;
            end
            else if (self_gt || (!valid_reg && left_valid))
            begin
                valid_next = 1'b1;
                val_next   = sample;
                age_next   = '0;
            end
            else if (valid_reg)
            begin
                age_next = age_reg + 1'b1;
            end
        end
        else if (ctrl.remove && prefix_out)
        begin
            valid_next = right_valid;
            val_next   = right_val;
            age_next   = right_age;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

endmodule
`default_nettype wire

[design/swm_gather.sv]
// Registered OR tree that collects the selected median entry from the cell chain.
`default_nettype none
module swm_gather #(
    parameter int N = 64
) (
    input  wire                                     clk,
    input  wire                                     capture,
    input  wire  [N-1:0][swm_pkg::SAMPLE_W-1:0]     lane_val,
    output logic [swm_pkg::SAMPLE_W-1:0]            result
);
    import swm_pkg::*;

    localparam int G = (N + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [G-1:0][SAMPLE_W-1:0] grp_reg;
    logic [G-1:0][SAMPLE_W-1:0] grp_next;

    always_comb
    begin
        for (int g = 0; g < G; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < N)
                begin
                    grp_next[g] = grp_next[g] | lane_val[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            grp_reg <= grp_next;
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < G; g++)
        begin
            result = result | grp_reg[g];
        end
    end

endmodule
`default_nettype wire

[design/sliding_window_median.sv]
// Top level of the sliding window median filter built from a chain of sorting cells.
`default_nettype none
// The filter keeps the last window_size samples in a chain of cells sorted by value and,
// once the window is full, returns the lower median for every new sample. A sample that
// does not complete the window is inserted as accepted: every cell compares itself with the
// sample and shifts up from its neighbor in the same cycle. A sample that completes the
// window passes three steps, the last held by any stall on the result side: the insert, a
// step that retires the oldest entry while the median is captured into a registered OR
// tree, and a step that moves the median into the output register. Writing window_size
// clears the window at once, so results restart with the window_size-th new sample (0
// acts as 1, above WINDOW_MAX as WINDOW_MAX); reset does the same with no clearing pass.
module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [swm_pkg::WS_W-1:0]         cfg_wdata,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [swm_pkg::SAMPLE_W-1:0]     sample,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [swm_pkg::SAMPLE_W-1:0]     median
);
    import swm_pkg::*;

    localparam int CW = ($clog2(WINDOW_MAX + 1) > WS_W) ? $clog2(WINDOW_MAX + 1) : WS_W;
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam logic [CW-1:0] WMAX = CW'(WINDOW_MAX);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REMOVE = 3'b010,
        ST_GATHER = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [WS_W-1:0]     ws_reg;
    logic [CW-1:0]       fill_reg;
    logic [CW-1:0]       fill_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] median_reg;

    logic [CW-1:0]       ws_ext;
    logic [CW-1:0]       k;
    logic [CW-1:0]       k_m1;
    logic [CW-1:0]       rank;
    logic [AW-1:0]       oldest;
    logic                accept;
    logic                out_free;
    swm_ctrl_t           ctrl;

    logic [WINDOW_MAX-1:0]               valid_w;
    logic [WINDOW_MAX-1:0]               gt_w;
    logic [WINDOW_MAX-1:0]               pre_w;
    logic [WINDOW_MAX-1:0][SAMPLE_W-1:0] val_w;
    logic [WINDOW_MAX-1:0][AW-1:0]       age_w;
    logic [WINDOW_MAX-1:0][SAMPLE_W-1:0] masked_w;
    logic [SAMPLE_W-1:0]                 gathered;

    assign ws_ext = CW'(ws_reg);
    assign k      = (ws_reg == '0) ? CW'(1) : ((ws_ext > WMAX) ? WMAX : ws_ext);
    assign k_m1   = k - 1'b1;
    assign rank   = k_m1 >> 1;
    assign oldest = k_m1[AW-1:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign median    = median_reg;

    assign ctrl.insert = accept;
    assign ctrl.remove = (state_reg == ST_REMOVE);
    assign ctrl.clear  = cfg_we;

    genvar i;
    generate
        for (i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            logic                lv;
            logic                lg;
            logic [SAMPLE_W-1:0] lval;
            logic [AW-1:0]       lage;
            logic                rv;
            logic [SAMPLE_W-1:0] rval;
            logic [AW-1:0]       rage;
            logic                pin;

            if (i == 0)
            begin : g_first
                assign lv   = 1'b1;
                assign lg   = 1'b0;
                assign lval = '0;
                assign lage = '0;
                assign pin  = 1'b0;
            end
            else
            begin : g_mid
                assign lv   = valid_w[i-1];
                assign lg   = gt_w[i-1];
                assign lval = val_w[i-1];
                assign lage = age_w[i-1];
                assign pin  = pre_w[i-1];
            end

            if (i == WINDOW_MAX - 1)
            begin : g_last
                assign rv   = 1'b0;
                assign rval = '0;
                assign rage = '0;
            end
            else
            begin : g_inner
                assign rv   = valid_w[i+1];
                assign rval = val_w[i+1];
                assign rage = age_w[i+1];
            end

            swm_cell #(
                .AW    (AW),
                .CW    (CW),
                .INDEX (i)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .sample      (sample),
                .oldest      (oldest),
                .rank        (rank),
                .left_valid  (lv),
                .left_gt     (lg),
                .left_val    (lval),
                .left_age    (lage),
                .right_valid (rv),
                .right_val   (rval),
                .right_age   (rage),
                .prefix_in   (pin),
                .self_valid  (valid_w[i]),
                .self_gt     (gt_w[i]),
                .self_val    (val_w[i]),
                .self_age    (age_w[i]),
                .prefix_out  (pre_w[i]),
                .masked_val  (masked_w[i])
            );
        end
    endgenerate

    swm_gather #(
        .N (WINDOW_MAX)
    ) u_gather (
        .clk      (clk),
        .capture  (state_reg == ST_REMOVE),
        .lane_val (masked_w),
        .result   (gathered)
    );

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fill_next = fill_reg + 1'b1;
                    if (fill_next == k)
                    begin
                        state_next = ST_REMOVE;
                    end
                end
            end
            ST_REMOVE:
            begin
                fill_next  = fill_reg - 1'b1;
                state_next = ST_GATHER;
            end
            ST_GATHER:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            fill_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_GATHER) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ws_reg        <= WS_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                ws_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_GATHER) && out_free)
        begin
            median_reg <= gathered;
        end
    end

    // The occupied cells always match the fill count.
    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_w) == fill_reg)
        else $error("cell valid bits disagree with the fill count");

    // Between transactions the window is never full.
    a_idle_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fill_reg < k))
        else $error("window full while idle");

    // The oldest entry is retired only from a full window, and at least one cell holds it.
    a_remove_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMOVE) |-> ((fill_reg == k) && pre_w[WINDOW_MAX-1]))
        else $error("retire step without a full window or without an oldest entry");

endmodule
`default_nettype wire

[dv/tb_sliding_window_median.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the sliding window median filter with its own window predictor.
module tb_sliding_window_median;

    import swm_pkg::*;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [WS_W-1:0]     cfg_wdata = WS_RESET;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SAMPLE_W-1:0] median;

    logic [SAMPLE_W-1:0] sample_backlog[$];
    logic [SAMPLE_W-1:0] expected_medians[$];

    logic [SAMPLE_W-1:0] win_vals[WINDOW_MAX_DEF];
    int                  win_ages[WINDOW_MAX_DEF];
    int                  win_fill;
    logic [WS_W-1:0]     win_size;

    int fail_count = 0;
    int samples_accepted = 0;
    int medians_checked = 0;
    int settings_used = 0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_cycle = 0;
    int stall_mode = 0;

    sliding_window_median DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median)
    );

    always #4 clk = ~clk;

    function automatic int active_size();
        if (win_size == 0)
            return 1;
        if (win_size > WINDOW_MAX_DEF)
            return WINDOW_MAX_DEF;
        return int'(win_size);
    endfunction

    function automatic void flush_window();
        for (int i = 0; i < WINDOW_MAX_DEF; i++)
        begin
            win_vals[i] = '0;
            win_ages[i] = 0;
        end
        win_fill = 0;
    endfunction

    // Insert a sample in sorted order, emit the lower median once full, then drop the oldest.
    function automatic void slide_window(input logic [SAMPLE_W-1:0] v);
        int k;
        int pos;
        int i;
        k = active_size();
        if (win_fill >= k)
            win_fill = 0;
        for (i = 0; i < win_fill; i++)
            win_ages[i] = win_ages[i] + 1;
        pos = win_fill;
        while (pos > 0 && win_vals[pos - 1] > v)
        begin
            win_vals[pos] = win_vals[pos - 1];
            win_ages[pos] = win_ages[pos - 1];
            pos--;
        end
        win_vals[pos] = v;
        win_ages[pos] = 0;
        win_fill++;
        if (win_fill < k)
            return;
        expected_medians = {expected_medians, win_vals[(k - 1) / 2]};
        i = 0;
        while (i < win_fill && win_ages[i] != k - 1)
            i++;
        if (i >= win_fill)
            i = win_fill - 1;
        for (; i + 1 < win_fill; i++)
        begin
            win_vals[i] = win_vals[i + 1];
            win_ages[i] = win_ages[i + 1];
        end
        win_vals[win_fill - 1] = '0;
        win_ages[win_fill - 1] = 0;
        win_fill--;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2: return SAMPLE_W'($urandom_range(0, 7));
            3: return SAMPLE_W'(SAMPLE_MAX);
            4: return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                slide_window(sample);
                samples_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_backlog.size() > 0)
                begin
                    sample <= sample_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every result transaction and stalls in changing patterns.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    $display("%0t: unexpected median %h, expected none", $time, median);
                    fail_count++;
                end
                else
                begin
                    if (median !== expected_medians[0])
                    begin
                        $display("%0t: median mismatch, expected %h, actual %h",
                                 $time, expected_medians[0], median);
                        fail_count++;
                    end
                    void'(expected_medians.pop_front());
                    medians_checked++;
                end
            end
            stall_cycle++;
            if (stall_cycle % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= (stall_cycle % 4 == 0);
                default: out_ready <= stall_cycle[3];
            endcase
        end
    end

    task automatic drain();
        while (sample_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_medians.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_window(input logic [WS_W-1:0] size);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= size;
        win_size = size;
        flush_window();
        settings_used++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [WS_W-1:0] size, input int count);
        set_window(size);
        for (int i = 0; i < count; i++)
            sample_backlog = {sample_backlog, pick_sample()};
        drain();
    endtask

    initial
    begin
        logic [WS_W-1:0] fixed_sizes[7] = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd65, 7'd5};
        logic [SAMPLE_W-1:0] directed[$] = '{
            '0, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX), '0, '0, '0,
            1, 2, 3, 4, 5, 4, 3, 2, 1,
            '0, SAMPLE_W'(SAMPLE_MAX), '0, SAMPLE_W'(SAMPLE_MAX),
            7, 7, 7, 30'h2AAAAAAA, 30'h15555555, 30'h20000000
        };
        win_size = WS_RESET;
        flush_window();
        settings_used = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples run with the window size left by reset.
        foreach (directed[i])
            sample_backlog = {sample_backlog, directed[i]};
        drain();

        foreach (fixed_sizes[i])
            run_phase(fixed_sizes[i], 110);
        for (int p = 0; p < 7; p++)
            run_phase(($urandom_range(0, 3) == 0) ? WS_W'($urandom_range(0, 127))
                                                  : WS_W'($urandom_range(1, 12)), 110);

        $display("Checked %0d medians from %0d samples over %0d window settings.",
                 medians_checked, samples_accepted, settings_used);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
